FILE: src/ter_pkg.sv
// Shared types and constants for the triangle edge rasterizer.
package ter_pkg;

	localparam int CoordBits = 16;
	localparam int DiffBits  = CoordBits + 1;
	localparam int ProdBits  = 2 * DiffBits;
	localparam int EdgeBits  = ProdBits + 2;
	localparam int PixBits   = 12;
	localparam int FrameBits = 13;
	localparam int ColorBits = 32;
	localparam int MaxDim    = 4096;

	localparam logic [FrameBits-1:0] FrameWidthRst  = FrameBits'(640);
	localparam logic [FrameBits-1:0] FrameHeightRst = FrameBits'(480);

	typedef enum logic {
		REQ_START = 1'b0,
		REQ_STEP  = 1'b1
	} req_t;

	typedef enum logic {
		CFG_FRAME_WIDTH  = 1'b0,
		CFG_FRAME_HEIGHT = 1'b1
	} cfg_idx_t;

	typedef logic signed [CoordBits-1:0] coord_t;
	typedef logic signed [DiffBits-1:0]  diff_t;
	typedef logic signed [ProdBits-1:0]  prod_t;
	typedef logic signed [EdgeBits-1:0]  edge_t;
	typedef logic [PixBits-1:0]          pix_t;
	typedef logic [ColorBits-1:0]        color_t;

	typedef struct packed {
		pix_t   x;
		pix_t   y;
		color_t color;
		logic   wr;
		logic   last;
	} pixel_t;

	// everything the walker needs to start a new triangle
	typedef struct packed {
		pix_t        min_x;
		pix_t        max_x;
		pix_t        min_y;
		pix_t        max_y;
		edge_t [2:0] w;
		diff_t [2:0] inc_x;
		diff_t [2:0] inc_y;
		logic        area_pos;
		color_t      color;
	} walk_load_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic degen;
	} setup_stat_t;

	localparam pixel_t IdlePixel = '{x: '0, y: '0, color: '0, wr: 1'b0, last: 1'b1};

endpackage

FILE: src/ter_setup.sv
// Triangle setup pipeline: bounding box, edge coefficients and starting edge values.
module ter_setup (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          launch,
	input  ter_pkg::coord_t               ax,
	input  ter_pkg::coord_t               ay,
	input  ter_pkg::coord_t               bx,
	input  ter_pkg::coord_t               by,
	input  ter_pkg::coord_t               cx,
	input  ter_pkg::coord_t               cy,
	input  ter_pkg::color_t               color,
	input  logic [ter_pkg::FrameBits-1:0] frame_w,
	input  logic [ter_pkg::FrameBits-1:0] frame_h,
	input  logic                          finish,
	output ter_pkg::setup_stat_t          stat,
	output ter_pkg::walk_load_t           load
);
	import ter_pkg::*;

	function automatic coord_t min3(input coord_t a, input coord_t b, input coord_t c);
		coord_t m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

	function automatic coord_t max3(input coord_t a, input coord_t b, input coord_t c);
		coord_t m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

	coord_t sx [3];
	coord_t sy [3];
	coord_t ex [3];
	coord_t ey [3];
	diff_t  dxa [3];
	diff_t  dya [3];
	diff_t  oxa [3];
	diff_t  oya [3];
	diff_t  lim_x, lim_y;
	diff_t  mnx, mxx, mny, mxy;
	coord_t vmin_x, vmax_x, vmin_y, vmax_y;
	logic   empty;

	logic   v_s2;
	diff_t  dx_s2 [3];
	diff_t  dy_s2 [3];
	diff_t  ox_s2 [3];
	diff_t  oy_s2 [3];
	pix_t   min_x_s2, max_x_s2, min_y_s2, max_y_s2;
	logic   empty_s2;
	color_t color_s2;

	logic   v_s3;
	prod_t  pa_s3 [3];
	prod_t  pb_s3 [3];
	prod_t  ar0_s3, ar1_s3;
	diff_t  dx_s3 [3];
	diff_t  dy_s3 [3];
	pix_t   min_x_s3, max_x_s3, min_y_s3, max_y_s3;
	logic   empty_s3;
	color_t color_s3;

	edge_t  area;

	// edge 0 runs b->c, edge 1 c->a, edge 2 a->b
	always_comb begin
		sx[0] = bx; sy[0] = by; ex[0] = cx; ey[0] = cy;
		sx[1] = cx; sy[1] = cy; ex[1] = ax; ey[1] = ay;
		sx[2] = ax; sy[2] = ay; ex[2] = bx; ey[2] = by;

		lim_x = (frame_w > FrameBits'(MaxDim)) ? DiffBits'(MaxDim - 1)
			: diff_t'({{(DiffBits-FrameBits){1'b0}}, frame_w}) - DiffBits'(1);
		lim_y = (frame_h > FrameBits'(MaxDim)) ? DiffBits'(MaxDim - 1)
			: diff_t'({{(DiffBits-FrameBits){1'b0}}, frame_h}) - DiffBits'(1);

		vmin_x = min3(ax, bx, cx);
		vmax_x = max3(ax, bx, cx);
		vmin_y = min3(ay, by, cy);
		vmax_y = max3(ay, by, cy);

		mnx = (vmin_x < 0) ? '0 : DiffBits'(vmin_x);
		mny = (vmin_y < 0) ? '0 : DiffBits'(vmin_y);
		mxx = (DiffBits'(vmax_x) < lim_x) ? DiffBits'(vmax_x) : lim_x;
		mxy = (DiffBits'(vmax_y) < lim_y) ? DiffBits'(vmax_y) : lim_y;
		empty = (mnx > mxx) || (mny > mxy);

		for (int i = 0; i < 3; i++) begin
			dxa[i] = DiffBits'(ex[i]) - DiffBits'(sx[i]);
			dya[i] = DiffBits'(ey[i]) - DiffBits'(sy[i]);
			oxa[i] = mnx - DiffBits'(sx[i]);
			oya[i] = mny - DiffBits'(sy[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= launch;
			v_s3 <= v_s2 | (v_s3 & ~finish);
		end
	end

	always_ff @(posedge clk) begin
		if (launch) begin
			for (int i = 0; i < 3; i++) begin
				dx_s2[i] <= dxa[i];
				dy_s2[i] <= dya[i];
				ox_s2[i] <= oxa[i];
				oy_s2[i] <= oya[i];
			end
			min_x_s2 <= mnx[PixBits-1:0];
			max_x_s2 <= mxx[PixBits-1:0];
			min_y_s2 <= mny[PixBits-1:0];
			max_y_s2 <= mxy[PixBits-1:0];
			empty_s2 <= empty;
			color_s2 <= color;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			for (int i = 0; i < 3; i++) begin
				pa_s3[i] <= ox_s2[i] * dy_s2[i];
				pb_s3[i] <= oy_s2[i] * dx_s2[i];
				dx_s3[i] <= dx_s2[i];
				dy_s3[i] <= dy_s2[i];
			end
			ar0_s3   <= dy_s2[1] * dx_s2[2];
			ar1_s3   <= dx_s2[1] * dy_s2[2];
			min_x_s3 <= min_x_s2;
			max_x_s3 <= max_x_s2;
			min_y_s3 <= min_y_s2;
			max_y_s3 <= max_y_s2;
			empty_s3 <= empty_s2;
			color_s3 <= color_s2;
		end
	end

	always_comb begin
		area = EdgeBits'(ar0_s3) - EdgeBits'(ar1_s3);

		stat.busy  = v_s2 | v_s3;
		stat.done  = v_s3;
		stat.degen = (area == '0) || empty_s3;

		load.min_x    = min_x_s3;
		load.max_x    = max_x_s3;
		load.min_y    = min_y_s3;
		load.max_y    = max_y_s3;
		load.area_pos = ~area[EdgeBits-1];
		load.color    = color_s3;
		for (int i = 0; i < 3; i++) begin
			load.w[i]     = EdgeBits'(pa_s3[i]) - EdgeBits'(pb_s3[i]);
			load.inc_x[i] = dy_s3[i];
			load.inc_y[i] = -dx_s3[i];
		end
	end

endmodule

FILE: src/ter_walk.sv
// Bounding box walker with incremental edge function evaluation.
module ter_walk (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load_en,
	input  logic                kill,
	input  ter_pkg::walk_load_t load,
	input  logic                step_en,
	output ter_pkg::pixel_t     pix
);
	import ter_pkg::*;

	logic   active_q;
	pix_t   cur_x_q, cur_y_q;
	pix_t   min_x_q, max_x_q, max_y_q;
	edge_t  w_q   [3];
	edge_t  row_q [3];
	diff_t  inc_x_q [3];
	diff_t  inc_y_q [3];
	logic   area_pos_q;
	color_t color_q;

	logic   all_ge, all_le, in_tri, last, row_end;

	always_comb begin
		all_ge = 1'b1;
		all_le = 1'b1;
		for (int i = 0; i < 3; i++) begin
			all_ge = all_ge & ~w_q[i][EdgeBits-1];
			all_le = all_le & (w_q[i][EdgeBits-1] | (w_q[i] == '0));
		end
		in_tri  = area_pos_q ? all_ge : all_le;
		row_end = (cur_x_q == max_x_q);
		last    = row_end && (cur_y_q == max_y_q);

		if (active_q) begin
			pix.x     = cur_x_q;
			pix.y     = cur_y_q;
			pix.color = color_q;
			pix.wr    = in_tri;
			pix.last  = last;
		end else begin
			pix = IdlePixel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (load_en) begin
			active_q <= 1'b1;
		end else if (kill) begin
			active_q <= 1'b0;
		end else if (step_en && active_q && last) begin
			active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			cur_x_q    <= load.min_x;
			cur_y_q    <= load.min_y;
			min_x_q    <= load.min_x;
			max_x_q    <= load.max_x;
			max_y_q    <= load.max_y;
			area_pos_q <= load.area_pos;
			color_q    <= load.color;
			for (int i = 0; i < 3; i++) begin
				w_q[i]     <= load.w[i];
				row_q[i]   <= load.w[i];
				inc_x_q[i] <= load.inc_x[i];
				inc_y_q[i] <= load.inc_y[i];
			end
		end else if (step_en && active_q && !last) begin
			if (row_end) begin
				// wrap to the start of the next row
				cur_x_q <= min_x_q;
				cur_y_q <= cur_y_q + PixBits'(1);
				for (int i = 0; i < 3; i++) begin
					row_q[i] <= row_q[i] + EdgeBits'(inc_y_q[i]);
					w_q[i]   <= row_q[i] + EdgeBits'(inc_y_q[i]);
				end
			end else begin
				cur_x_q <= cur_x_q + PixBits'(1);
				for (int i = 0; i < 3; i++) begin
					w_q[i] <= w_q[i] + EdgeBits'(inc_x_q[i]);
				end
			end
		end
	end

endmodule

FILE: src/ter_obuf.sv
// Two-entry output register with skid stage.
module ter_obuf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ter_pkg::pixel_t push_data,
	output logic            room,
	output logic            out_valid,
	input  logic            out_stall,
	output ter_pkg::pixel_t out_data
);
	import ter_pkg::*;

	logic   o_v_q, k_v_q;
	pixel_t o_q, k_q;
	logic   pop;

	assign pop       = o_v_q & ~out_stall;
	assign room      = ~k_v_q;
	assign out_valid = o_v_q;
	assign out_data  = o_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_v_q <= 1'b0;
			k_v_q <= 1'b0;
		end else if (pop) begin
			if (k_v_q) begin
				k_v_q <= 1'b0;
			end else begin
				o_v_q <= push;
			end
		end else if (push) begin
			if (o_v_q) begin
				k_v_q <= 1'b1;
			end else begin
				o_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (k_v_q) begin
				o_q <= k_q;
			end else if (push) begin
				o_q <= push_data;
			end
		end else if (push) begin
			if (o_v_q) begin
				k_q <= push_data;
			end else begin
				o_q <= push_data;
			end
		end
	end

endmodule

FILE: src/triangle_edge_rasterizer_unit.sv
// Step words: input register, then output register; one word per cycle with output room.
// Start words: setup pipeline (eight 17x17 products for the edge values and
// area); words behind a start wait until setup has loaded the walker.
// A degenerate or clipped-away start gives its result word from setup, not the walker.
// Reset (arst_n low, asynchronous): idle, output empty, frame size 640x480.
module triangle_edge_rasterizer_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [ter_pkg::FrameBits-1:0] cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          req_type,
	input  ter_pkg::coord_t               vert_a_x,
	input  ter_pkg::coord_t               vert_a_y,
	input  ter_pkg::coord_t               vert_b_x,
	input  ter_pkg::coord_t               vert_b_y,
	input  ter_pkg::coord_t               vert_c_x,
	input  ter_pkg::coord_t               vert_c_y,
	input  ter_pkg::color_t               fill_color,
	output logic                          out_valid,
	input  logic                          out_stall,
	output ter_pkg::pix_t                 pixel_x,
	output ter_pkg::pix_t                 pixel_y,
	output ter_pkg::color_t               pixel_color,
	output logic                          write_pixel,
	output logic                          last_pixel
);
	import ter_pkg::*;

	logic [FrameBits-1:0] frame_w_q, frame_h_q;

	logic   v_s1;
	req_t   req_s1;
	coord_t ax_s1, ay_s1, bx_s1, by_s1, cx_s1, cy_s1;
	color_t color_s1;

	logic        s1_go, accept, launch, step_en, finish, push, room;
	setup_stat_t stat;
	walk_load_t  load;
	pixel_t      walk_pix, push_data, out_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_w_q <= FrameWidthRst;
			frame_h_q <= FrameHeightRst;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_FRAME_WIDTH:  frame_w_q <= cfg_wdata;
				CFG_FRAME_HEIGHT: frame_h_q <= cfg_wdata;
			endcase
		end
	end

	// a step needs output room and the setup pipe free; a start only needs the setup pipe free
	assign s1_go    = v_s1 && !stat.busy && ((req_s1 == REQ_START) || room);
	assign in_stall = v_s1 && !s1_go;
	assign accept   = in_valid && !in_stall;
	assign launch   = s1_go && (req_s1 == REQ_START);
	assign step_en  = s1_go && (req_s1 == REQ_STEP);
	assign finish   = stat.done && (!stat.degen || room);
	assign push     = step_en || (finish && stat.degen);
	assign push_data = step_en ? walk_pix : IdlePixel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (s1_go) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1   <= req_t'(req_type);
			ax_s1    <= vert_a_x;
			ay_s1    <= vert_a_y;
			bx_s1    <= vert_b_x;
			by_s1    <= vert_b_y;
			cx_s1    <= vert_c_x;
			cy_s1    <= vert_c_y;
			color_s1 <= fill_color;
		end
	end

	ter_setup u_setup (
		.clk     (clk),
		.arst_n  (arst_n),
		.launch  (launch),
		.ax      (ax_s1),
		.ay      (ay_s1),
		.bx      (bx_s1),
		.by      (by_s1),
		.cx      (cx_s1),
		.cy      (cy_s1),
		.color   (color_s1),
		.frame_w (frame_w_q),
		.frame_h (frame_h_q),
		.finish  (finish),
		.stat    (stat),
		.load    (load)
	);

	ter_walk u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.load_en (finish && !stat.degen),
		.kill    (finish && stat.degen),
		.load    (load),
		.step_en (step_en),
		.pix     (walk_pix)
	);

	ter_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign pixel_x     = out_data.x;
	assign pixel_y     = out_data.y;
	assign pixel_color = out_data.color;
	assign write_pixel = out_data.wr;
	assign last_pixel  = out_data.last;

endmodule

FILE: src/ter_checker.sv
// Port-level checks for the rasterizer, bound to the top level.
module ter_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [ter_pkg::PixBits-1:0] pixel_x,
	input logic [ter_pkg::PixBits-1:0] pixel_y,
	input ter_pkg::color_t             pixel_color,
	input logic                        write_pixel,
	input logic                        last_pixel
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
			&& $stable(pixel_color) && $stable(write_pixel) && $stable(last_pixel))
		else $error("result word changed while stalled");

	// input stall only rises after a word was taken in
	a_stall_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid))
		else $error("in_stall rose with no word held");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !out_valid && !in_stall)
		else $error("block not idle in reset");

endmodule

bind triangle_edge_rasterizer_unit ter_checker u_ter_checker (.*);
